>>> design/assert_macros.svh
// Assertion helper macros for the instruction encoder.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RVIE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RVIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

>>> design/rvie_pkg.sv
// Shared types, opcode constants and the mnemonic table of the RV32IM encoder.
// Depends on nothing; imported by every module of the block.
package rvie_pkg;

    localparam int MN_COUNT = 47;

    // Mnemonic indexes in table order; anything past MN_EBREAK is rejected
    typedef enum logic [5:0] {
        MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA, MN_OR, MN_AND,
        MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU, MN_DIV, MN_DIVU, MN_REM, MN_REMU,
        MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_SRAI, MN_ORI, MN_ANDI,
        MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_LUI, MN_AUIPC, MN_SB, MN_SH, MN_SW,
        MN_JAL, MN_JALR, MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_ECALL, MN_EBREAK
    } rvie_mnemonic_t;

    // Instruction formats
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_S = 3'd2;
    localparam logic [2:0] FMT_B = 3'd3;
    localparam logic [2:0] FMT_U = 3'd4;
    localparam logic [2:0] FMT_J = 3'd5;

    // Major opcodes: five-bit group in [6:2], low two bits always 11
    localparam logic [6:0] OP_LOAD   = {5'h00, 2'b11};
    localparam logic [6:0] OP_OPIMM  = {5'h04, 2'b11};
    localparam logic [6:0] OP_AUIPC  = {5'h05, 2'b11};
    localparam logic [6:0] OP_STORE  = {5'h08, 2'b11};
    localparam logic [6:0] OP_OP     = {5'h0C, 2'b11};
    localparam logic [6:0] OP_LUI    = {5'h0D, 2'b11};
    localparam logic [6:0] OP_BRANCH = {5'h18, 2'b11};
    localparam logic [6:0] OP_JALR   = {5'h19, 2'b11};
    localparam logic [6:0] OP_JAL    = {5'h1B, 2'b11};
    localparam logic [6:0] OP_SYSTEM = {5'h1C, 2'b11};

    // funct7 column values; in I/S formats these are ORed into the immediate
    localparam logic [10:0] F7_NONE  = 11'h000;
    localparam logic [10:0] F7_ALT   = 11'h020;
    localparam logic [10:0] F7_MULDV = 11'h001;
    localparam logic [10:0] F7_SRAI  = 11'h400;   // 0x20 << 5
    localparam logic [10:0] F7_EBRK  = 11'h001;

    typedef struct packed {
        logic [2:0]  fmt;
        logic [6:0]  major;
        logic [2:0]  f3;
        logic [10:0] f7;
    } rvie_row_t;

    typedef struct packed {
        logic [5:0]         mnemonic;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
    } rvie_in_t;

    typedef struct packed {
        logic [31:0] instruction_word;
        logic        bad_mnemonic;
    } rvie_out_t;

    // Decoder result handed to the packer
    typedef struct packed {
        rvie_row_t row;
        logic      bad;
    } rvie_dec_t;

    localparam rvie_row_t ENC_TABLE [MN_COUNT] = '{
        // add sub sll slt sltu xor srl sra or and
        '{FMT_R, OP_OP, 3'd0, F7_NONE}, '{FMT_R, OP_OP, 3'd0, F7_ALT},
        '{FMT_R, OP_OP, 3'd1, F7_NONE}, '{FMT_R, OP_OP, 3'd2, F7_NONE},
        '{FMT_R, OP_OP, 3'd3, F7_NONE}, '{FMT_R, OP_OP, 3'd4, F7_NONE},
        '{FMT_R, OP_OP, 3'd5, F7_NONE}, '{FMT_R, OP_OP, 3'd5, F7_ALT},
        '{FMT_R, OP_OP, 3'd6, F7_NONE}, '{FMT_R, OP_OP, 3'd7, F7_NONE},
        // mul mulh mulhsu mulhu div divu rem remu
        '{FMT_R, OP_OP, 3'd0, F7_MULDV}, '{FMT_R, OP_OP, 3'd1, F7_MULDV},
        '{FMT_R, OP_OP, 3'd2, F7_MULDV}, '{FMT_R, OP_OP, 3'd3, F7_MULDV},
        '{FMT_R, OP_OP, 3'd4, F7_MULDV}, '{FMT_R, OP_OP, 3'd5, F7_MULDV},
        '{FMT_R, OP_OP, 3'd6, F7_MULDV}, '{FMT_R, OP_OP, 3'd7, F7_MULDV},
        // addi slli slti sltiu xori srli srai ori andi
        '{FMT_I, OP_OPIMM, 3'd0, F7_NONE}, '{FMT_I, OP_OPIMM, 3'd1, F7_NONE},
        '{FMT_I, OP_OPIMM, 3'd2, F7_NONE}, '{FMT_I, OP_OPIMM, 3'd3, F7_NONE},
        '{FMT_I, OP_OPIMM, 3'd4, F7_NONE}, '{FMT_I, OP_OPIMM, 3'd5, F7_NONE},
        '{FMT_I, OP_OPIMM, 3'd5, F7_SRAI}, '{FMT_I, OP_OPIMM, 3'd6, F7_NONE},
        '{FMT_I, OP_OPIMM, 3'd7, F7_NONE},
        // lb lh lw lbu lhu
        '{FMT_I, OP_LOAD, 3'd0, F7_NONE}, '{FMT_I, OP_LOAD, 3'd1, F7_NONE},
        '{FMT_I, OP_LOAD, 3'd2, F7_NONE}, '{FMT_I, OP_LOAD, 3'd4, F7_NONE},
        '{FMT_I, OP_LOAD, 3'd5, F7_NONE},
        // lui auipc
        '{FMT_U, OP_LUI, 3'd0, F7_NONE}, '{FMT_U, OP_AUIPC, 3'd0, F7_NONE},
        // sb sh sw
        '{FMT_S, OP_STORE, 3'd0, F7_NONE}, '{FMT_S, OP_STORE, 3'd1, F7_NONE},
        '{FMT_S, OP_STORE, 3'd2, F7_NONE},
        // jal jalr
        '{FMT_J, OP_JAL, 3'd0, F7_NONE}, '{FMT_I, OP_JALR, 3'd0, F7_NONE},
        // beq bne blt bge bltu bgeu
        '{FMT_B, OP_BRANCH, 3'd0, F7_NONE}, '{FMT_B, OP_BRANCH, 3'd1, F7_NONE},
        '{FMT_B, OP_BRANCH, 3'd4, F7_NONE}, '{FMT_B, OP_BRANCH, 3'd5, F7_NONE},
        '{FMT_B, OP_BRANCH, 3'd6, F7_NONE}, '{FMT_B, OP_BRANCH, 3'd7, F7_NONE},
        // ecall ebreak
        '{FMT_I, OP_SYSTEM, 3'd0, F7_NONE}, '{FMT_I, OP_SYSTEM, 3'd0, F7_EBRK}
    };

endpackage

>>> design/rvie_decode.sv
// Mnemonic lookup: table row and out-of-range flag.
// Depends on rvie_pkg.
module rvie_decode
    import rvie_pkg::*;
(
    input  logic [5:0] mnemonic,
    output rvie_dec_t  dec
);

    always_comb
    begin
        if (mnemonic < 6'(MN_COUNT))
        begin
            dec.row = ENC_TABLE[mnemonic];
            dec.bad = 1'b0;
        end
        else
        begin
            dec.row = '0;
            dec.bad = 1'b1;
        end
    end

endmodule

>>> design/rvie_pack.sv
// Field packing of one instruction word by format.
// Depends on rvie_pkg; fed by rvie_decode.
module rvie_pack
    import rvie_pkg::*;
(
    input  rvie_in_t  inst,
    input  rvie_dec_t dec,
    output rvie_out_t enc
);

    logic [31:0] imm;
    logic [31:0] imm_or;
    logic [31:0] word;

    assign imm    = 32'(inst.immediate);
    assign imm_or = imm | {21'd0, dec.row.f7};

    always_comb
    begin
        case (dec.row.fmt)
            FMT_R:
                word = {dec.row.f7[6:0], inst.src2_reg, inst.src1_reg, dec.row.f3,
                        inst.dest_reg, dec.row.major};
            FMT_I:
                word = {imm_or[11:0], inst.src1_reg, dec.row.f3, inst.dest_reg,
                        dec.row.major};
            FMT_S:
                word = {imm_or[11:5], inst.src2_reg, inst.src1_reg, dec.row.f3,
                        imm_or[4:0], dec.row.major};
            FMT_B:
                word = {imm[12], imm[10:5], inst.src2_reg, inst.src1_reg, dec.row.f3,
                        imm[4:1], imm[11], dec.row.major};
            FMT_U:
                word = {imm[19:0], inst.dest_reg, dec.row.major};
            default: // J format
                word = {imm[20], imm[10:1], imm[11], imm[19:12], inst.dest_reg,
                        dec.row.major};
        endcase
    end

    assign enc.instruction_word = dec.bad ? 32'd0 : word;
    assign enc.bad_mnemonic     = dec.bad;

endmodule

>>> design/rv32im_instruction_encoder.sv
// RV32IM encoder: an inst transaction reaches enc valid through two registers
// (input register, then result register). Throughput one transaction per cycle while enc_ready is high.
// The decode and packing between the two registers is a table lookup plus muxing.
// rst_n (async, active low) empties both stages; payload registers are not reset.
// in ready drops only when both stages hold data and enc_ready is low.
// Depends on rvie_pkg, rvie_decode, rvie_pack and assert_macros.svh.
`include "assert_macros.svh"
module rv32im_instruction_encoder
    import rvie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // instruction side
    input  logic      inst_valid,
    output logic      inst_ready,
    input  rvie_in_t  inst,
    // encoded word side
    output logic      enc_valid,
    input  logic      enc_ready,
    output rvie_out_t enc
);

    // Stage 1: captured instruction
    logic      s1_valid_reg;
    logic      s1_valid_next;
    rvie_in_t  s1_inst_reg;

    // Stage 2: encoded result waiting for the consumer
    logic      s2_valid_reg;
    logic      s2_valid_next;
    rvie_out_t s2_enc_reg;

    logic      s1_adv;      // stage 1 moves into stage 2 this cycle
    logic      inst_fire;
    rvie_dec_t dec;
    rvie_out_t enc_comb;

    // Stage 2 frees up when empty or being drained; stage 1 frees up when it advances.
    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || enc_ready);
    assign inst_ready = !s1_valid_reg || s1_adv;
    assign inst_fire  = inst_valid && inst_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (inst_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
            s2_valid_next = 1'b1;
        else if (enc_ready)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (inst_fire)
            s1_inst_reg <= inst;
        if (s1_adv)
            s2_enc_reg <= enc_comb;
    end

    // Table lookup then format packing, all between the two registers
    rvie_decode u_decode (
        .mnemonic (s1_inst_reg.mnemonic),
        .dec      (dec)
    );

    rvie_pack u_pack (
        .inst (s1_inst_reg),
        .dec  (dec),
        .enc  (enc_comb)
    );

    assign enc_valid = s2_valid_reg;
    assign enc       = s2_enc_reg;

    // A rejected mnemonic always carries a zero word
    `RVIE_ASSERT_NOW(a_bad_zero, clk, rst_n, enc_valid && enc.bad_mnemonic, enc.instruction_word == 32'd0)
    // Every legal encoding ends in the 32-bit opcode marker
    `RVIE_ASSERT_NOW(a_op_low, clk, rst_n, enc_valid && !enc.bad_mnemonic, enc.instruction_word[1:0] == 2'b11)
    // Back pressure only when both stages are occupied
    `RVIE_ASSERT_NOW(a_stall_full, clk, rst_n, !inst_ready, s1_valid_reg && s2_valid_reg)
    // A stage 1 advance always lands a result in stage 2
    `RVIE_ASSERT_NEXT(a_adv_lands, clk, rst_n, s1_adv, enc_valid)

endmodule

>>> test/rv32im_instruction_encoder_checker.sv
`timescale 1ns / 1ps
// Transaction checker for the RV32IM encoder: predicts each encoded word and compares.
// Depends on rvie_pkg for the channel payload types and mnemonic codes.
module rv32im_instruction_encoder_checker
    import rvie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        inst_valid,
    input  logic        inst_ready,
    input  rvie_in_t    inst,
    input  logic        enc_valid,
    input  logic        enc_ready,
    input  rvie_out_t   enc,
    output int unsigned failures,
    output int unsigned pending,
    output int unsigned words_checked
);

    localparam int unsigned REPORT_LIMIT = 10;

    localparam logic [2:0] FORM_R = 3'd0;
    localparam logic [2:0] FORM_I = 3'd1;
    localparam logic [2:0] FORM_S = 3'd2;
    localparam logic [2:0] FORM_B = 3'd3;
    localparam logic [2:0] FORM_U = 3'd4;
    localparam logic [2:0] FORM_J = 3'd5;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct7 column; I/S forms OR it into the immediate (srai, ebreak)
    localparam logic [10:0] F7_BASE   = 11'h000;
    localparam logic [10:0] F7_ALT    = 11'h020;
    localparam logic [10:0] F7_MULDIV = 11'h001;
    localparam logic [10:0] F7_SRAI   = 11'h400;
    localparam logic [10:0] F7_BREAK  = 11'h001;

    rvie_out_t encodings_due [$];

    function automatic rvie_out_t encode_expected(rvie_in_t t);
        logic [2:0]  form;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [10:0] f7;
        logic [31:0] imm;
        rvie_out_t   r;
        r = '0;
        {form, opc, f3, f7} = '0;
        case (t.mnemonic)
            MN_ADD:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd0, F7_BASE};
            MN_SUB:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd0, F7_ALT};
            MN_SLL:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd1, F7_BASE};
            MN_SLT:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd2, F7_BASE};
            MN_SLTU:   {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd3, F7_BASE};
            MN_XOR:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd4, F7_BASE};
            MN_SRL:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd5, F7_BASE};
            MN_SRA:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd5, F7_ALT};
            MN_OR:     {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd6, F7_BASE};
            MN_AND:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd7, F7_BASE};
            MN_MUL:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd0, F7_MULDIV};
            MN_MULH:   {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd1, F7_MULDIV};
            MN_MULHSU: {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd2, F7_MULDIV};
            MN_MULHU:  {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd3, F7_MULDIV};
            MN_DIV:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd4, F7_MULDIV};
            MN_DIVU:   {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd5, F7_MULDIV};
            MN_REM:    {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd6, F7_MULDIV};
            MN_REMU:   {form, opc, f3, f7} = {FORM_R, OPC_OP, 3'd7, F7_MULDIV};
            MN_ADDI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd0, F7_BASE};
            MN_SLLI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd1, F7_BASE};
            MN_SLTI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd2, F7_BASE};
            MN_SLTIU:  {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd3, F7_BASE};
            MN_XORI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd4, F7_BASE};
            MN_SRLI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd5, F7_BASE};
            MN_SRAI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd5, F7_SRAI};
            MN_ORI:    {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd6, F7_BASE};
            MN_ANDI:   {form, opc, f3, f7} = {FORM_I, OPC_OPIMM, 3'd7, F7_BASE};
            MN_LB:     {form, opc, f3, f7} = {FORM_I, OPC_LOAD, 3'd0, F7_BASE};
            MN_LH:     {form, opc, f3, f7} = {FORM_I, OPC_LOAD, 3'd1, F7_BASE};
            MN_LW:     {form, opc, f3, f7} = {FORM_I, OPC_LOAD, 3'd2, F7_BASE};
            MN_LBU:    {form, opc, f3, f7} = {FORM_I, OPC_LOAD, 3'd4, F7_BASE};
            MN_LHU:    {form, opc, f3, f7} = {FORM_I, OPC_LOAD, 3'd5, F7_BASE};
            MN_LUI:    {form, opc, f3, f7} = {FORM_U, OPC_LUI, 3'd0, F7_BASE};
            MN_AUIPC:  {form, opc, f3, f7} = {FORM_U, OPC_AUIPC, 3'd0, F7_BASE};
            MN_SB:     {form, opc, f3, f7} = {FORM_S, OPC_STORE, 3'd0, F7_BASE};
            MN_SH:     {form, opc, f3, f7} = {FORM_S, OPC_STORE, 3'd1, F7_BASE};
            MN_SW:     {form, opc, f3, f7} = {FORM_S, OPC_STORE, 3'd2, F7_BASE};
            MN_JAL:    {form, opc, f3, f7} = {FORM_J, OPC_JAL, 3'd0, F7_BASE};
            MN_JALR:   {form, opc, f3, f7} = {FORM_I, OPC_JALR, 3'd0, F7_BASE};
            MN_BEQ:    {form, opc, f3, f7} = {FORM_B, OPC_BRANCH, 3'd0, F7_BASE};
            MN_BNE:    {form, opc, f3, f7} = {FORM_B, OPC_BRANCH, 3'd1, F7_BASE};
            MN_BLT:    {form, opc, f3, f7} = {FORM_B, OPC_BRANCH, 3'd4, F7_BASE};
            MN_BGE:    {form, opc, f3, f7} = {FORM_B, OPC_BRANCH, 3'd5, F7_BASE};
            MN_BLTU:   {form, opc, f3, f7} = {FORM_B, OPC_BRANCH, 3'd6, F7_BASE};
            MN_BGEU:   {form, opc, f3, f7} = {FORM_B, OPC_BRANCH, 3'd7, F7_BASE};
            MN_ECALL:  {form, opc, f3, f7} = {FORM_I, OPC_SYSTEM, 3'd0, F7_BASE};
            MN_EBREAK: {form, opc, f3, f7} = {FORM_I, OPC_SYSTEM, 3'd0, F7_BREAK};
            default:   r.bad_mnemonic = 1'b1;
        endcase
        if (r.bad_mnemonic)
        begin
            return r;
        end
        imm = t.immediate;
        case (form)
            FORM_R:
                r.instruction_word = {f7[6:0], t.src2_reg, t.src1_reg, f3, t.dest_reg, opc};
            FORM_I:
            begin
                imm = imm | {21'd0, f7};
                r.instruction_word = {imm[11:0], t.src1_reg, f3, t.dest_reg, opc};
            end
            FORM_S:
            begin
                imm = imm | {21'd0, f7};
                r.instruction_word = {imm[11:5], t.src2_reg, t.src1_reg, f3, imm[4:0], opc};
            end
            FORM_B:
                r.instruction_word = {imm[12], imm[10:5], t.src2_reg, t.src1_reg, f3,
                                      imm[4:1], imm[11], opc};
            FORM_U:
                r.instruction_word = {imm[19:0], t.dest_reg, opc};
            default:
                r.instruction_word = {imm[20], imm[10:1], imm[11], imm[19:12],
                                      t.dest_reg, opc};
        endcase
        return r;
    endfunction

    task automatic note_failure(string what, rvie_out_t want, rvie_out_t got);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected word %08h bad %b, got word %08h bad %b",
                     $realtime, what, want.instruction_word, want.bad_mnemonic,
                     got.instruction_word, got.bad_mnemonic);
        end
    endtask

    initial
    begin
        failures      = 0;
        pending       = 0;
        words_checked = 0;
    end

    // Output side first, so an encoding with nothing queued is caught before
    // a same-edge input transaction is queued.
    always @(posedge clk)
    begin
        rvie_out_t want;
        if (rst_n)
        begin
            if (enc_valid && enc_ready)
            begin
                words_checked++;
                if (encodings_due.size() == 0)
                begin
                    note_failure("encoding with none pending", '0, enc);
                end
                else
                begin
                    want = encodings_due.pop_front();
                    if (enc.instruction_word !== want.instruction_word)
                        note_failure("instruction_word mismatch", want, enc);
                    else if (enc.bad_mnemonic !== want.bad_mnemonic)
                        note_failure("bad_mnemonic mismatch", want, enc);
                end
            end
            if (inst_valid && inst_ready)
            begin
                encodings_due.push_back(encode_expected(inst));
            end
            pending = encodings_due.size();
        end
    end

endmodule

>>> test/rv32im_instruction_encoder_tb.sv
`timescale 1ns / 1ps
// Top of the RV32IM encoder testbench: clock, reset, stimulus and verdict.
// Depends on rvie_pkg, rv32im_instruction_encoder and rv32im_instruction_encoder_checker.
module rv32im_instruction_encoder_tb
    import rvie_pkg::*;
();

    localparam int HALF_PERIOD = 10;
    localparam int TIMEOUT_NS  = 20_000_000;   // far above a correct run
    localparam int LONG_HOLD   = 64;           // output stall that backs up both stages
    localparam int DRAIN_CYCLES = 4;           // two-stage pipe plus margin

    // Indexes past the table
    localparam logic [5:0] MN_FIRST_BAD = 6'(MN_COUNT);
    localparam logic [5:0] MN_TOP_BAD   = 6'h3F;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      inst_valid;
    logic      inst_ready;
    rvie_in_t  inst;
    logic      enc_valid;
    logic      enc_ready;
    rvie_out_t enc;

    int unsigned failures;
    int unsigned pending;
    int unsigned words_checked;

    // Stimulus knobs shared with the receiver process
    bit idle_on = 1'b1;
    int holds_asked  = 0;
    int holds_served = 0;

    int unsigned insts_sent = 0;
    int unsigned bad_sent   = 0;

    always #(HALF_PERIOD) clk = ~clk;

    rv32im_instruction_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .inst_valid (inst_valid),
        .inst_ready (inst_ready),
        .inst       (inst),
        .enc_valid  (enc_valid),
        .enc_ready  (enc_ready),
        .enc        (enc)
    );

    rv32im_instruction_encoder_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .inst_valid    (inst_valid),
        .inst_ready    (inst_ready),
        .inst          (inst),
        .enc_valid     (enc_valid),
        .enc_ready     (enc_ready),
        .enc           (enc),
        .failures      (failures),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // Offer one instruction transaction. Entered and left at a falling edge.
    // An optional idle burst comes first; valid then stays high until accepted.
    task automatic drive_inst(input logic [5:0] mn, input logic [4:0] rd,
                              input logic [4:0] rs1, input logic [4:0] rs2,
                              input logic [31:0] imm);
        rvie_in_t t;
        t.mnemonic  = mn;
        t.dest_reg  = rd;
        t.src1_reg  = rs1;
        t.src2_reg  = rs2;
        t.immediate = imm;
        if (idle_on && $urandom_range(7) == 0)
        begin
            inst_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(negedge clk);
        end
        inst       <= t;
        inst_valid <= 1'b1;
        @(posedge clk);
        while (!inst_ready) @(posedge clk);
        @(negedge clk);
        insts_sent++;
        if (mn >= MN_FIRST_BAD)
            bad_sent++;
    endtask

    // Mostly table entries; about one in eight falls past the table.
    function automatic logic [5:0] pick_mnemonic();
        if ($urandom_range(7) == 0)
            return 6'($urandom_range(MN_TOP_BAD, MN_FIRST_BAD));
        return 6'($urandom_range(MN_COUNT - 1));
    endfunction

    // Mix of full-range words, 12-bit signed offsets, extremes, walking-one and walking-zero patterns
    function automatic logic [31:0] pick_immediate();
        logic [31:0] walk;
        walk = 32'd1 << $urandom_range(31);
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return 32'($urandom_range(4095)) - 32'd2048;
            3:
            begin
                case ($urandom_range(3))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            4:       return walk;
            default: return ~walk;
        endcase
    endfunction

    task automatic drive_random(input int count);
        repeat (count)
        begin
            drive_inst(pick_mnemonic(), 5'($urandom_range(31)), 5'($urandom_range(31)),
                       5'($urandom_range(31)), pick_immediate());
        end
    endtask

    // Sender pauses with valid low until the checker has every word back
    task automatic drain_pause();
        inst_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Output side: random ready bursts, long holds on request, steady ready
    // once idling is switched off. One assignment per falling edge at most.
    initial
    begin
        forever
        begin
            if (holds_served != holds_asked)
            begin
                holds_served++;
                enc_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (idle_on && $urandom_range(5) == 0)
            begin
                enc_ready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(negedge clk);
            end
            else
            begin
                enc_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d encodings still due", pending);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        inst_valid = 1'b0;
        inst       = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extreme fields, each format, the immediate OR and bad indexes
        drive_inst(MN_ADD,    5'd0,  5'd0,  5'd0,  32'h0000_0000);
        drive_inst(MN_ADD,    5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);  // immediate unused
        drive_inst(MN_SUB,    5'd5,  5'd10, 5'd21, 32'h7FFF_FFFF);
        drive_inst(MN_MUL,    5'd1,  5'd2,  5'd3,  32'h8000_0000);
        drive_inst(MN_REMU,   5'd31, 5'd0,  5'd31, 32'h0000_0000);
        drive_inst(MN_ADDI,   5'd31, 5'd31, 5'd31, 32'h0000_07FF);  // rs2 unused
        drive_inst(MN_ADDI,   5'd1,  5'd1,  5'd0,  32'hFFFF_F800);
        drive_inst(MN_ADDI,   5'd2,  5'd3,  5'd0,  32'h8000_0000);  // bits above 11 dropped
        drive_inst(MN_SLLI,   5'd4,  5'd5,  5'd0,  32'h0000_0405);  // caller bit 10: srai
        drive_inst(MN_SRAI,   5'd6,  5'd7,  5'd0,  32'h0000_0000);
        drive_inst(MN_SRAI,   5'd6,  5'd7,  5'd0,  32'h0000_001F);
        drive_inst(MN_LW,     5'd8,  5'd2,  5'd0,  32'hFFFF_FFFF);
        drive_inst(MN_LUI,    5'd31, 5'd31, 5'd31, 32'h000F_FFFF);
        drive_inst(MN_LUI,    5'd9,  5'd0,  5'd0,  32'hFFF0_0000);  // high bits dropped
        drive_inst(MN_AUIPC,  5'd10, 5'd0,  5'd0,  32'hFFFF_FFFF);
        drive_inst(MN_SB,     5'd31, 5'd11, 5'd12, 32'hFFFF_F800);  // rd unused
        drive_inst(MN_SW,     5'd0,  5'd31, 5'd31, 32'h0000_07FF);
        drive_inst(MN_JAL,    5'd1,  5'd0,  5'd0,  32'h0000_0001);  // bit 0 dropped
        drive_inst(MN_JAL,    5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF);
        drive_inst(MN_JALR,   5'd0,  5'd1,  5'd0,  32'hFFFF_FFFF);
        drive_inst(MN_BEQ,    5'd31, 5'd13, 5'd14, 32'hFFFF_F000);
        drive_inst(MN_BGEU,   5'd0,  5'd31, 5'd31, 32'h0000_0FFF);
        drive_inst(MN_ECALL,  5'd3,  5'd7,  5'd9,  32'h0000_0000);  // rd/rs1 packed as given
        drive_inst(MN_EBREAK, 5'd0,  5'd0,  5'd0,  32'hFFFF_FFFF);
        drive_inst(MN_FIRST_BAD, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
        drive_inst(MN_TOP_BAD,   5'd0,  5'd0,  5'd0,  32'h0000_0000);
        drain_pause();

        // Random with idling on both sides
        drive_random(450);

        // Long output hold while the sender keeps offering: both stages fill
        // and inst_ready must drop until the receiver lets go.
        holds_asked++;
        drive_random(100);
        drain_pause();

        drive_random(350);
        holds_asked++;
        drive_random(100);

        // Final stretch at full rate, no bubbles on either side
        idle_on = 1'b0;
        drive_random(400);

        inst_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d instruction transactions (%0d past the table),",
                 insts_sent, bad_sent);
        $display("%0d encodings checked, idle bursts, %0d long output holds, full-rate tail",
                 words_checked, holds_served);
        if (failures == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
